>>> rtl/core/fraction_to_boundary_step_macros.svh
// assertion macros used by the port-level checker
`ifndef FRACTION_TO_BOUNDARY_STEP_MACROS_SVH
`define FRACTION_TO_BOUNDARY_STEP_MACROS_SVH

// same-cycle implication, disabled during reset
`define FBS_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define FBS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define FBS_ASSERT_ALWAYS(lbl, clk, pre, post) \
   lbl: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> rtl/core/fbs_pkg.sv
// types, constants and codes of the fraction-to-boundary step block
package fbs_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TAU_W      = FRAC_BITS + 1;
   localparam int MAG_W      = DATA_WIDTH + 1;
   localparam int NUM_W      = MAG_W + TAU_W;
   localparam int DEN_W      = DATA_WIDTH;
   localparam int QUO_W      = FRAC_BITS + 1;
   localparam int CNT_W      = $clog2(QUO_W);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam longint ONE_INT = longint'(1) << FRAC_BITS;
   localparam logic [TAU_W-1:0] ONE       = TAU_W'(ONE_INT);
   localparam logic [TAU_W-1:0] TAU_RESET = TAU_W'((ONE_INT * 99 + 50) / 100);

   localparam logic [CSR_IDX_W-1:0] REG_TAU = CSR_IDX_W'(0);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quo;
   } div_sts_type;

endpackage

>>> rtl/core/fbs_channels.sv
// valid/ready channel interfaces for entry and step-length beats
interface fbs_req_if;
   import fbs_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [DATA_WIDTH-1:0] value;
   logic signed [DATA_WIDTH-1:0] bound;
   logic signed [DATA_WIDTH-1:0] direction;
   logic                         last;

   modport source (output valid, mode, value, bound, direction, last, input ready);
   modport sink (input valid, mode, value, bound, direction, last, output ready);
endinterface

interface fbs_rsp_if;
   import fbs_pkg::*;
   logic             valid;
   logic             ready;
   logic [TAU_W-1:0] max_step;

   modport source (output valid, max_step, input ready);
   modport sink (input valid, max_step, output ready);
endinterface

>>> rtl/core/fbs_csr.sv
// apb register file holding the tau factor
module fbs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fbs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fbs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [fbs_pkg::TAU_W-1:0]      tau
);
   import fbs_pkg::*;

   logic [TAU_W-1:0]     tau_ff;
   logic [TAU_W-1:0]     tau_in;
   logic [CSR_IDX_W-1:0] idx;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready && (idx == REG_TAU);
   assign tau_in     = wr_en ? csr_pwdata[TAU_W-1:0] : tau_ff;
   assign tau        = tau_ff;

   always_comb begin
      case (idx)
         REG_TAU: csr_prdata = CSR_DATA_W'(tau_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tau_ff <= TAU_RESET;
      end else begin
         tau_ff <= tau_in;
      end
   end
endmodule

>>> rtl/core/fbs_div.sv
// restoring divider with one shared subtract-compare unit and saturation check
module fbs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fbs_pkg::div_ctl_type ctl,
   output fbs_pkg::div_sts_type sts
);
   import fbs_pkg::*;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             chk_ff, chk_in;
   logic             done_ff, done_in;

   logic [NUM_W-1:0] den_ext;
   logic [NUM_W-1:0] lim;
   logic [DEN_W:0]   trial;
   logic [NUM_W-1:0] op_a, op_b;
   logic [NUM_W:0]   diff;
   logic             ge;

   assign den_ext = NUM_W'(den_ff);
   assign lim     = (den_ext << FRAC_BITS) + den_ext;
   assign trial   = {rem_ff[DEN_W-1:0], num_ff[QUO_W-1]};
   assign op_a    = chk_ff ? num_ff : NUM_W'(trial);
   assign op_b    = chk_ff ? lim : den_ext;
   assign diff    = {1'b0, op_a} - {1'b0, op_b};
   assign ge      = !diff[NUM_W];

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      chk_in  = chk_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         num_in  = ctl.num;
         den_in  = ctl.den;
         cnt_in  = '0;
         busy_in = 1'b1;
         chk_in  = 1'b1;
      end else if (busy_ff && chk_ff) begin
         chk_in = 1'b0;
         if (ge) begin
            quo_in  = ONE;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = (DEN_W + 1)'(num_ff >> QUO_W);
            quo_in = '0;
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W:0] : trial;
         quo_in = {quo_ff[QUO_W-2:0], ge};
         num_in = num_ff << 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         chk_ff  <= chk_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign sts.done = done_ff;
   assign sts.quo  = quo_ff;
endmodule

>>> rtl/core/fraction_to_boundary_step.sv
// a candidate entry runs a full divide, but a saturating quotient ends the divide after its
// check step; an entry without a candidate skips the divider; the shared divider runs one check
// step, then one quotient bit per cycle over 17 bits; a last entry gives the result beat and
// waits while the previous result beat has not been taken
// reset: synchronous, clears sequencer, result beat and running minimum to 1.0, tau to 0.99
module fraction_to_boundary_step (
   input  logic                           clock,
   input  logic                           reset,
   fbs_req_if.sink                        req_bus,
   fbs_rsp_if.source                      rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fbs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fbs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import fbs_pkg::*;

   state_type state_ff, state_in;

   logic                         mode_ff;
   logic                         last_ff;
   logic signed [DATA_WIDTH-1:0] value_ff, bound_ff, dir_ff;
   logic [MAG_W-1:0]             mag_ff, mag_in;
   logic [DEN_W-1:0]             den_ff, den_in;
   logic                         cand_ff, cand_in;
   logic [TAU_W-1:0]             q_ff;
   logic [TAU_W-1:0]             run_ff, run_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [TAU_W-1:0]             rsp_step_ff, rsp_step_in;

   logic [TAU_W-1:0]             tau;
   logic [TAU_W-1:0]             teff;
   logic                         vgt, vlt, dneg, dnz;
   logic signed [MAG_W-1:0]      vdiff;
   logic [NUM_W-1:0]             prod;
   logic [TAU_W-1:0]             upd;
   logic                         rsp_free;
   logic                         accept;
   div_ctl_type                  div_ctl;
   div_sts_type                  div_sts;

   fbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .tau         (tau)
   );

   fbs_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   assign accept   = req_bus.valid && req_bus.ready;
   assign teff     = (tau > ONE) ? ONE : tau;
   assign vgt      = value_ff > bound_ff;
   assign vlt      = value_ff < bound_ff;
   assign dneg     = dir_ff[DATA_WIDTH-1];
   assign dnz      = |dir_ff;
   assign vdiff    = {value_ff[DATA_WIDTH-1], value_ff} - {bound_ff[DATA_WIDTH-1], bound_ff};
   assign mag_in   = vgt ? MAG_W'(vdiff) : MAG_W'(-vdiff);
   assign den_in   = dneg ? DEN_W'(-dir_ff) : DEN_W'(dir_ff);
   assign cand_in  = (mode_ff ? (!dneg && dnz && vlt) : (dneg && vgt)) && (teff != '0);
   assign prod     = mag_ff * teff;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign upd      = (cand_ff && (q_ff < run_ff)) ? q_ff : run_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_PREP;
         ST_PREP: state_in = ST_MUL;
         ST_MUL:  state_in = cand_ff ? ST_DIV : ST_DONE;
         ST_DIV:  if (div_sts.done) state_in = ST_DONE;
         ST_DONE: if (!last_ff || rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_bus.ready = 1'b0;
      div_ctl.start = 1'b0;
      div_ctl.num   = prod;
      div_ctl.den   = den_ff;
      case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_MUL:  div_ctl.start = cand_ff;
         default: req_bus.ready = 1'b0;
      endcase
   end

   always_comb begin
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_step_in  = rsp_step_ff;
      if (state_ff == ST_DONE) begin
         if (!last_ff) begin
            run_in = upd;
         end else if (rsp_free) begin
            run_in       = ONE;
            rsp_valid_in = 1'b1;
            rsp_step_in  = upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_step_ff <= rsp_step_in;
      if (accept) begin
         mode_ff  <= req_bus.mode;
         value_ff <= req_bus.value;
         bound_ff <= req_bus.bound;
         dir_ff   <= req_bus.direction;
         last_ff  <= req_bus.last;
      end
      if (state_ff == ST_PREP) begin
         mag_ff  <= mag_in;
         den_ff  <= den_in;
         cand_ff <= cand_in;
      end
      if (state_ff == ST_DIV && div_sts.done) begin
         q_ff <= (div_sts.quo == '0) ? QUO_W'(1) : div_sts.quo;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.max_step = rsp_step_ff;
endmodule

>>> rtl/core/fbs_checker.sv
// port-level checker for the fraction-to-boundary step block, with its bind
`include "fraction_to_boundary_step_macros.svh"

module fbs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [fbs_pkg::TAU_W-1:0] rsp_max_step
);
   import fbs_pkg::*;

   `FBS_ASSERT_NOW(a_step_range, clock, reset, rsp_valid, (|rsp_max_step) && (rsp_max_step <= ONE))
   `FBS_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && req_ready, !req_ready)
   `FBS_ASSERT_NEXT(a_no_instant_result, clock, reset, req_valid && req_ready, !$rose(rsp_valid))
   `FBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_max_step))
   `FBS_ASSERT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)
endmodule

bind fraction_to_boundary_step fbs_checker u_fbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_max_step (rsp_bus.max_step)
);

>>> tb/fbs_checker.sv
// checker: predicts step lengths from observed beats and compares them with the block output
module fbs_scoreboard (
   input  logic                           clock,
   input  logic                           reset,
   fbs_req_if                             req_bus,
   fbs_rsp_if                             rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fbs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             mismatch_count,
   output int                             steps_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import fbs_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [TAU_W-1:0] tau_q;
   logic [TAU_W-1:0] running_step;
   logic [TAU_W-1:0] steps_due[$];
   int               errors;

   initial begin
      mismatch_count = 0;
      steps_pending  = 0;
      errors         = 0;
      tau_q          = TAU_RESET;
      running_step   = ONE;
   end

   // distance to the bound, clipped to (0, 1.0]; zero when the entry gives no candidate
   function automatic logic [TAU_W-1:0] boundary_distance(
      input logic                         side,
      input logic signed [DATA_WIDTH-1:0] value_i,
      input logic signed [DATA_WIDTH-1:0] bound_i,
      input logic signed [DATA_WIDTH-1:0] dir_i,
      input logic [TAU_W-1:0]             tau_i
   );
      longint v, b, d, t, mag, den, quo;
      bit     cand;
      v = value_i;
      b = bound_i;
      d = dir_i;
      t = (tau_i > ONE) ? ONE_INT : longint'(tau_i);
      if (side == 1'b0) begin
         cand = (d < 0) && (v > b);
      end else begin
         cand = (d > 0) && (v < b);
      end
      if (!cand || t == 0) return '0;
      mag = (v > b) ? (v - b) : (b - v);
      den = (d < 0) ? -d : d;
      quo = (mag * t) / den;
      if (quo == 0) quo = 1;
      if (quo > ONE_INT) quo = ONE_INT;
      return TAU_W'(quo);
   endfunction

   always @(posedge clock) begin
      logic [TAU_W-1:0] cand_step;
      logic [TAU_W-1:0] due;
      if (reset) begin
         tau_q        = TAU_RESET;
         running_step = ONE;
         steps_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[CSR_ADDR_W-1:2] == REG_TAU) begin
            tau_q = csr_pwdata[TAU_W-1:0];
         end
         if (req_bus.valid && req_bus.ready) begin
            cand_step = boundary_distance(req_bus.mode, req_bus.value, req_bus.bound,
                                          req_bus.direction, tau_q);
            if (cand_step != 0 && cand_step < running_step) running_step = cand_step;
            if (req_bus.last) begin
               steps_due.push_back(running_step);
               running_step = ONE;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (steps_due.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%t unexpected step length beat: got %0d", $realtime,
                           rsp_bus.max_step);
            end else begin
               due = steps_due.pop_front();
               if (rsp_bus.max_step !== due) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%t step length mismatch: expected %0d got %0d", $realtime,
                              due, rsp_bus.max_step);
               end
            end
         end
      end
      steps_pending  <= steps_due.size();
      mismatch_count <= errors;
   end

endmodule

>>> tb/tb_top.sv
// testbench top: clock, reset, entry and register stimulus, result sink and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fbs_pkg::*;

   localparam int IDLE_PCT        = 33;
   localparam int HOLD_CYCLES     = 400;
   localparam int SETTLE_CYCLES   = 30;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PHASES          = 30;
   localparam int ITEMS_PER_PHASE = 26;
   localparam int CALM_PHASE      = 6;
   localparam int PRESSURE_PHASE  = 12;
   localparam int BURST_ITEMS     = 16;

   localparam logic [CSR_ADDR_W-1:0] TAU_ADDR   = CSR_ADDR_W'(REG_TAU) << 2;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(1) << 2;

   localparam logic signed [DATA_WIDTH-1:0] FIX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] FIX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] FIX_ONE = DATA_WIDTH'(ONE_INT);

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    steps_pending;
   bit                    calm;
   bit                    hold_request;

   fbs_req_if req_bus ();
   fbs_rsp_if rsp_bus ();

   fraction_to_boundary_step dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fbs_scoreboard u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .steps_pending  (steps_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_entry(
      input logic                         side,
      input logic signed [DATA_WIDTH-1:0] value_i,
      input logic signed [DATA_WIDTH-1:0] bound_i,
      input logic signed [DATA_WIDTH-1:0] dir_i,
      input logic                         last_i
   );
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= side;
      req_bus.value     <= value_i;
      req_bus.bound     <= bound_i;
      req_bus.direction <= dir_i;
      req_bus.last      <= last_i;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, wait for every step length, then let the divider finish
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (steps_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_fixed();
      logic signed [DATA_WIDTH-1:0] mag;
      case ($urandom_range(0, 9))
         0, 1: return $urandom();
         2: begin
            case ($urandom_range(0, 4))
               0: return FIX_MIN;
               1: return FIX_MAX;
               2: return '0;
               3: return 1;
               default: return -1;
            endcase
         end
         default: begin
            mag = $urandom_range(0, 1 << 20);
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_tau_word();
      logic [CSR_DATA_W-1:0] data;
      data = $urandom();
      case ($urandom_range(0, 7))
         0: data[TAU_W-1:0] = TAU_RESET;
         1: data[TAU_W-1:0] = '0;
         2: data[TAU_W-1:0] = TAU_W'(1);
         3: data[TAU_W-1:0] = ONE;
         4: data[TAU_W-1:0] = ONE - TAU_W'(1);
         5: data[TAU_W-1:0] = TAU_W'($urandom_range(32'(ONE_INT + 1), 32'(2 * ONE_INT - 1)));
         default: data[TAU_W-1:0] = TAU_W'($urandom_range(0, 32'(ONE_INT)));
      endcase
      return data;
   endfunction

   // mostly entries that face their bound, the rest raw noise
   task automatic send_random_entry(input logic last_i);
      logic                         side;
      logic signed [DATA_WIDTH-1:0] v, b, d, swap;
      side = $urandom_range(0, 1);
      v    = pick_fixed();
      b    = ($urandom_range(0, 2) == 0) ? '0 : pick_fixed();
      d    = pick_fixed();
      if ($urandom_range(0, 99) < 75) begin
         if ((side == 1'b0 && v < b) || (side == 1'b1 && v > b)) begin
            swap = v;
            v    = b;
            b    = swap;
         end
         if ((side == 1'b0 && d > 0) || (side == 1'b1 && d < 0)) d = -d;
         if (d == 0) d = side ? 1 : -1;
      end
      send_entry(side, v, b, d, last_i);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int sent;
      int run_len;
      reset             <= 1'b1;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.mode      <= 1'b0;
      req_bus.value     <= '0;
      req_bus.bound     <= '0;
      req_bus.direction <= '0;
      req_bus.last      <= 1'b0;
      calm         = 1'b0;
      hold_request = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed entries at the reset tau
      send_entry(1'b0, 2 * FIX_ONE, '0, -4 * FIX_ONE, 1'b0);
      send_entry(1'b0, 1, '0, FIX_MIN, 1'b1);
      send_entry(1'b1, FIX_MIN, FIX_MAX, 1, 1'b1);
      send_entry(1'b1, '0, FIX_ONE, FIX_MAX, 1'b0);
      send_entry(1'b0, FIX_MAX, FIX_MIN, -1, 1'b1);
      send_entry(1'b0, FIX_ONE, '0, FIX_ONE, 1'b0);
      send_entry(1'b1, '0, FIX_ONE, -FIX_ONE, 1'b0);
      send_entry(1'b0, FIX_ONE, '0, '0, 1'b0);
      send_entry(1'b1, '0, FIX_ONE, '0, 1'b0);
      send_entry(1'b0, 12345, 12345, -1, 1'b0);
      send_entry(1'b0, '0, FIX_ONE, -FIX_ONE, 1'b0);
      send_entry(1'b1, FIX_ONE, '0, FIX_ONE, 1'b1);
      send_entry(1'b0, -1, FIX_MIN, FIX_MIN, 1'b1);
      send_entry(1'b1, -FIX_ONE, '0, FIX_ONE / 2, 1'b1);

      drain_and_settle();
      csr_write(TAU_ADDR, '0);
      send_entry(1'b0, FIX_ONE, '0, -2 * FIX_ONE, 1'b1);

      drain_and_settle();
      csr_write(TAU_ADDR, '1);
      send_entry(1'b0, FIX_ONE, '0, -2 * FIX_ONE, 1'b1);
      send_entry(1'b1, '0, FIX_ONE, FIX_ONE, 1'b1);

      drain_and_settle();
      csr_write(TAU_ADDR, CSR_DATA_W'(ONE));
      send_entry(1'b0, 3, '0, -4, 1'b1);

      drain_and_settle();
      csr_write(TAU_ADDR, CSR_DATA_W'(1));
      send_entry(1'b0, FIX_ONE, '0, -2 * FIX_ONE, 1'b1);

      drain_and_settle();
      csr_write(SPARE_ADDR, $urandom());
      csr_write(TAU_ADDR, CSR_DATA_W'(TAU_RESET));
      send_entry(1'b0, FIX_ONE, '0, -2 * FIX_ONE, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_and_settle();
         csr_write(TAU_ADDR, pick_tau_word());
         calm = (phase == CALM_PHASE);
         if (phase == PRESSURE_PHASE) begin
            hold_request = 1'b1;
            for (int k = 0; k < BURST_ITEMS; k++) send_random_entry($urandom_range(0, 1));
            send_random_entry(1'b1);
         end
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++) send_random_entry(k == run_len - 1);
            sent += run_len;
         end
      end
      calm = 1'b0;

      drain_and_settle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/fbs_pkg.sv
rtl/core/fbs_channels.sv
rtl/core/fbs_csr.sv
rtl/core/fbs_div.sv
rtl/core/fraction_to_boundary_step.sv
rtl/core/fbs_checker.sv
tb/fbs_checker.sv
tb/tb_top.sv
